/* hw/rtl/dmg_pkg.sv */
// ----------------------------------------------------------------------------
// dmg_pkg: shared types, constants and functions of the maze generator
// Holds the datapath command and status structs, request codes, the
// direction table and the random number helpers.
// ----------------------------------------------------------------------------
package dmg_pkg;

    // Default sizes for the top-level parameters
    localparam int DEF_MAX_WIDTH   = 64;
    localparam int DEF_MAX_HEIGHT  = 64;
    localparam int DEF_STACK_DEPTH = 1024;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_MAZE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAZE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLE_RATE   = 2'd2;
    localparam int SIZE_W     = 7;
    localparam int RATE_W     = 10;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd31;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 7'd5;
    localparam logic [RATE_W-1:0] RATE_MAX   = 10'd1000;

    // Payload widths
    localparam int SEED_W  = 32;
    localparam int COORD_W = 6;

    // Request and response codes
    localparam logic REQ_GENERATE = 1'b0;
    localparam logic REQ_READ     = 1'b1;
    localparam logic RESP_GEN     = 1'b0;
    localparam logic RESP_READ    = 1'b1;

    // Iterative divider: 32-bit dividend, narrow divisor
    localparam int DIVN_W = 32;
    localparam int DIV_W  = 10;

    // Direction codes: low nibble is dx+1, high nibble is dy+1
    localparam logic [7:0] DIR_CODES [4] = '{8'h10, 8'h12, 8'h01, 8'h21};

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_GEN_START,
        OP_CLR,
        OP_OPEN_START,
        OP_SHUF,
        OP_PROBE,
        OP_OPEN_MID,
        OP_OPEN_DST,
        OP_POP_RD,
        OP_POP_LOAD,
        OP_HMUL1,
        OP_HMUL2,
        OP_DIVK,
        OP_KLOAD,
        OP_HSEL,
        OP_DIVX,
        OP_XLOAD,
        OP_DIVY,
        OP_YWRITE,
        OP_READ
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] idx;    // shuffle slot or probe slot
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic probe_hit;
        logic stack_empty;
        logic div_busy;
        logic k_zero;
        logic rd_wall;
    } t_dp_stat;

    // One xorshift32 step
    function automatic logic [31:0] xorshift32(input logic [31:0] w);
        logic [31:0] t;
        t = w ^ (w << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    // v mod 3 by folding base-4 digits (4^k is 1 mod 3)
    function automatic logic [1:0] mod3_32(input logic [31:0] v);
        logic [5:0] s;
        logic [3:0] s2;
        s = '0;
        for (int i = 0; i < 16; i++) begin
            s = s + 6'(v[2*i +: 2]);
        end
        s2 = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
        if (s2 >= 4'd6) begin
            s2 = s2 - 4'd6;
        end else if (s2 >= 4'd3) begin
            s2 = s2 - 4'd3;
        end
        return s2[1:0];
    endfunction

endpackage

/* hw/rtl/dmg_req_if.sv */
// ----------------------------------------------------------------------------
// dmg_req_if: request channel
// Valid/ready channel carrying one generate or read request item.
// ----------------------------------------------------------------------------
interface dmg_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] random_seed;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;

    modport source (output valid, req_type, random_seed, cell_x, cell_y, input ready);
    modport sink   (input valid, req_type, random_seed, cell_x, cell_y, output ready);
endinterface

/* hw/rtl/dmg_resp_if.sv */
// ----------------------------------------------------------------------------
// dmg_resp_if: response channel
// Valid/ready channel carrying one response item per request.
// ----------------------------------------------------------------------------
interface dmg_resp_if;
    logic valid;
    logic ready;
    logic resp_kind;
    logic cell_is_wall;

    modport source (output valid, resp_kind, cell_is_wall, input ready);
    modport sink   (input valid, resp_kind, cell_is_wall, output ready);
endinterface

/* hw/rtl/dmg_datapath.sv */
// ----------------------------------------------------------------------------
// dmg_datapath: grid, stack, random generator and divider
// Executes one operation per cycle as commanded by the controller and
// reports status flags back.
// ----------------------------------------------------------------------------
module dmg_datapath
    import dmg_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [SEED_W-1:0]     i_seed,
    input  logic [COORD_W-1:0]    i_cell_x,
    input  logic [COORD_W-1:0]    i_cell_y,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int GD  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW  = $clog2(GD);
    localparam int SPW = $clog2(STACK_DEPTH);
    localparam int SDW = $clog2(STACK_DEPTH + 1);
    localparam int P1W = $clog2(GD + 1);
    localparam int P2W = $clog2((GD / 2) * 1000 + 1);
    localparam int KW  = $clog2(GD / 2 + 1);
    localparam int DCW = $clog2(DIVN_W);

    // Divide by 1000 as multiply by a rounded-up reciprocal and shift
    localparam int KSH = 40;
    localparam int KRW = 31;
    localparam logic [KRW-1:0] K_RECIP = KRW'(((64'd1 << KSH) + 64'd999) / 64'd1000);
    localparam int KMW = P2W + KRW;

    // Configuration registers
    logic [SIZE_W-1:0] r_cfg_w, r_cfg_h;
    logic [RATE_W-1:0] r_cfg_rate;

    // Per-generate sizes
    logic [WW-1:0]     r_w;
    logic [HW-1:0]     r_h;
    logic [RATE_W-1:0] r_rate;

    // Walk state
    logic [31:0]    r_prng;
    logic [1:0]     r_order [4];
    logic [XW-1:0]  r_cx, r_nx, r_mx, r_hx;
    logic [YW-1:0]  r_cy, r_ny, r_my;
    logic [SDW-1:0] r_depth;
    logic [AW-1:0]  r_clr;
    logic           r_probe_ok;
    logic           r_gen_done;
    logic           r_rd_ok;
    logic           r_hsel;

    // Memories
    logic           mem_grid [GD];
    logic           r_grid_q;
    logic [XW+YW-1:0] mem_stk [STACK_DEPTH];
    logic [XW+YW-1:0] r_stk_q;

    // Hole count arithmetic
    logic [P1W-1:0] r_prod1;
    logic [P2W-1:0] r_prod2;
    logic [KMW-1:0] r_kmul;
    logic [KW-1:0]  r_k;

    // Divider
    logic              r_div_busy;
    logic [DCW-1:0]    r_div_cnt;
    logic [DIV_W-1:0]  r_div_rem;
    logic [DIVN_W-1:0] r_div_q;
    logic [DIV_W-1:0]  r_div_d;

    function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x, input logic [YW-1:0] y);
        return AW'(int'(y) * MAX_WIDTH + int'(x));
    endfunction

    // Saturated sizes
    logic [WW-1:0]     sat_w;
    logic [HW-1:0]     sat_h;
    logic [RATE_W-1:0] sat_rate;
    always_comb begin
        if (r_cfg_w < SIZE_MIN) begin
            sat_w = WW'(SIZE_MIN);
        end else if (int'(r_cfg_w) > MAX_WIDTH) begin
            sat_w = WW'(MAX_WIDTH);
        end else begin
            sat_w = WW'(r_cfg_w);
        end
        if (r_cfg_h < SIZE_MIN) begin
            sat_h = HW'(SIZE_MIN);
        end else if (int'(r_cfg_h) > MAX_HEIGHT) begin
            sat_h = HW'(MAX_HEIGHT);
        end else begin
            sat_h = HW'(r_cfg_h);
        end
        sat_rate = (r_cfg_rate > RATE_MAX) ? RATE_MAX : r_cfg_rate;
    end

    // Next random word
    logic [31:0] prng_nxt;
    assign prng_nxt = xorshift32(r_prng);

    // Shuffle swap target
    logic [1:0] shuf_n;
    always_comb begin
        unique case (i_cmd.idx)
            2'd3:    shuf_n = prng_nxt[1:0];
            2'd2:    shuf_n = mod3_32(prng_nxt);
            default: shuf_n = {1'b0, prng_nxt[0]};
        endcase
    end

    // Neighbor probe
    logic [7:0]             p_code;
    logic signed [2:0]      p_dx, p_dy;
    logic signed [XW+1:0]   p_nx;
    logic signed [YW+1:0]   p_ny;
    logic                   p_ok;
    always_comb begin
        p_code = DIR_CODES[r_order[i_cmd.idx]];
        p_dx   = $signed({1'b0, p_code[1:0]}) - 3'sd1;
        p_dy   = $signed({1'b0, p_code[5:4]}) - 3'sd1;
        p_nx   = $signed({2'b00, r_cx}) + ((XW+2)'(p_dx) <<< 1);
        p_ny   = $signed({2'b00, r_cy}) + ((YW+2)'(p_dy) <<< 1);
        p_ok   = !p_nx[XW+1] && (p_nx < $signed({1'b0, r_w}))
              && !p_ny[YW+1] && (p_ny < $signed({1'b0, r_h}));
    end

    // Divider step and start operands
    logic [DIV_W:0]    d_trial;
    logic              d_ge;
    logic [DIV_W-1:0]  w_half, h_half;
    logic              div_start;
    logic [DIVN_W-1:0] div_num;
    logic [DIV_W-1:0]  div_den;
    always_comb begin
        d_trial = {r_div_rem, r_div_q[DIVN_W-1]};
        d_ge    = d_trial >= {1'b0, r_div_d};
        w_half  = DIV_W'(r_w >> 1);
        h_half  = DIV_W'(r_h >> 1);
        div_start = 1'b0;
        div_num   = prng_nxt;
        div_den   = w_half;
        unique case (i_cmd.op)
            OP_DIVX: begin
                div_start = 1'b1;
                div_den   = r_hsel ? w_half - 1'b1 : w_half;
            end
            OP_DIVY: begin
                div_start = 1'b1;
                div_den   = r_hsel ? h_half : h_half - 1'b1;
            end
            default: ;
        endcase
    end

    // Grid write and read port selection
    logic          g_we, g_wd, g_re;
    logic [AW-1:0] g_wa, g_ra;
    logic [YW-1:0] hole_y;
    always_comb begin
        hole_y = YW'({r_div_rem, 1'b0}) + (r_hsel ? YW'(1) : YW'(2));
        g_we = 1'b0;
        g_wd = 1'b0;
        g_wa = r_clr;
        g_re = 1'b0;
        g_ra = cell_addr(XW'(i_cell_x), YW'(i_cell_y));
        unique case (i_cmd.op)
            OP_CLR: begin
                g_we = 1'b1;
                g_wd = 1'b1;
            end
            OP_OPEN_START: begin
                g_we = 1'b1;
                g_wa = cell_addr(XW'(1), YW'(1));
            end
            OP_OPEN_MID: begin
                g_we = 1'b1;
                g_wa = cell_addr(r_mx, r_my);
            end
            OP_OPEN_DST: begin
                g_we = 1'b1;
                g_wa = cell_addr(r_nx, r_ny);
            end
            OP_YWRITE: begin
                g_we = 1'b1;
                g_wa = cell_addr(r_hx, hole_y);
            end
            OP_PROBE: begin
                g_re = 1'b1;
                g_ra = cell_addr(XW'(p_nx), YW'(p_ny));
            end
            OP_READ: begin
                g_re = 1'b1;
            end
            default: ;
        endcase
    end

    // Grid memory
    always_ff @(posedge i_clk) begin
        if (g_we) begin
            mem_grid[g_wa] <= g_wd;
        end
        if (g_re) begin
            r_grid_q <= mem_grid[g_ra];
        end
    end

    // Backtrack stack memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OPEN_MID && int'(r_depth) < STACK_DEPTH) begin
            mem_stk[r_depth[SPW-1:0]] <= {r_cy, r_cx};
        end
        if (i_cmd.op == OP_POP_RD) begin
            r_stk_q <= mem_stk[SPW'(r_depth - 1'b1)];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= SIZE_RESET;
            r_cfg_h    <= SIZE_RESET;
            r_cfg_rate <= '0;
            r_depth    <= '0;
            r_gen_done <= 1'b0;
            r_div_busy <= 1'b0;
            r_div_cnt  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAZE_WIDTH:  r_cfg_w    <= i_cfg_data[SIZE_W-1:0];
                    CFG_MAZE_HEIGHT: r_cfg_h    <= i_cfg_data[SIZE_W-1:0];
                    CFG_HOLE_RATE:   r_cfg_rate <= i_cfg_data[RATE_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_GEN_START) begin
                r_depth    <= '0;
                r_gen_done <= 1'b1;
            end else if (i_cmd.op == OP_OPEN_MID && int'(r_depth) < STACK_DEPTH) begin
                r_depth <= r_depth + 1'b1;
            end else if (i_cmd.op == OP_POP_RD) begin
                r_depth <= r_depth - 1'b1;
            end
            if (div_start) begin
                r_div_busy <= 1'b1;
                r_div_cnt  <= DCW'(DIVN_W - 1);
            end else if (r_div_busy) begin
                r_div_cnt <= r_div_cnt - 1'b1;
                if (r_div_cnt == '0) begin
                    r_div_busy <= 1'b0;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        // divider shift
        if (div_start) begin
            r_div_rem <= '0;
            r_div_q   <= div_num;
            r_div_d   <= div_den;
        end else if (r_div_busy) begin
            r_div_rem <= d_ge ? DIV_W'(d_trial - {1'b0, r_div_d}) : DIV_W'(d_trial);
            r_div_q   <= {r_div_q[DIVN_W-2:0], d_ge};
        end
        unique case (i_cmd.op)
            OP_GEN_START: begin
                r_prng  <= (i_seed == '0) ? 32'd1 : i_seed;
                r_order <= '{2'd0, 2'd1, 2'd2, 2'd3};
                r_cx    <= XW'(1);
                r_cy    <= YW'(1);
                r_clr   <= '0;
                r_w     <= sat_w;
                r_h     <= sat_h;
                r_rate  <= sat_rate;
            end
            OP_CLR: begin
                r_clr <= r_clr + 1'b1;
            end
            OP_SHUF: begin
                r_prng            <= prng_nxt;
                r_order[shuf_n]   <= r_order[i_cmd.idx];
                r_order[i_cmd.idx] <= r_order[shuf_n];
            end
            OP_PROBE: begin
                r_probe_ok <= p_ok;
                r_nx       <= XW'(p_nx);
                r_ny       <= YW'(p_ny);
                r_mx       <= XW'($signed({1'b0, r_cx}) + (XW+1)'(p_dx));
                r_my       <= YW'($signed({1'b0, r_cy}) + (YW+1)'(p_dy));
            end
            OP_OPEN_DST: begin
                r_cx <= r_nx;
                r_cy <= r_ny;
            end
            OP_POP_LOAD: begin
                {r_cy, r_cx} <= r_stk_q;
            end
            OP_HMUL1: begin
                r_prod1 <= P1W'(r_w * r_h);
            end
            OP_HMUL2: begin
                r_prod2 <= P2W'((r_prod1 >> 1) * r_rate);
            end
            OP_DIVK: begin
                r_kmul <= KMW'(r_prod2) * KMW'(K_RECIP);
            end
            OP_KLOAD: begin
                r_k <= KW'(r_kmul >> KSH);
            end
            OP_HSEL: begin
                r_prng <= prng_nxt;
                r_hsel <= prng_nxt[0];
            end
            OP_DIVX, OP_DIVY: begin
                r_prng <= prng_nxt;
            end
            OP_XLOAD: begin
                r_hx <= XW'({r_div_rem, 1'b0}) + (r_hsel ? XW'(2) : XW'(1));
            end
            OP_YWRITE: begin
                r_k <= r_k - 1'b1;
            end
            OP_READ: begin
                r_rd_ok <= r_gen_done && (int'(i_cell_x) < MAX_WIDTH)
                        && (int'(i_cell_y) < MAX_HEIGHT);
            end
            default: ;
        endcase
    end

    // Status to controller
    assign o_stat.clr_last    = (int'(r_clr) == GD - 1);
    assign o_stat.probe_hit   = r_probe_ok & r_grid_q;
    assign o_stat.stack_empty = (r_depth == '0);
    assign o_stat.div_busy    = r_div_busy;
    assign o_stat.k_zero      = (r_k == '0);
    assign o_stat.rd_wall     = !r_rd_ok | r_grid_q;

    // Checks
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_depth) <= STACK_DEPTH)
        else $error("stack depth beyond capacity");
    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !r_div_busy)
        else $error("divider restarted while busy");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_POP_RD) |-> (r_depth != '0))
        else $error("pop from empty stack");

endmodule

/* hw/rtl/dmg_ctrl.sv */
// ----------------------------------------------------------------------------
// dmg_ctrl: request sequencer
// State machine that steps the datapath through grid clear, carving walk,
// backtracking, hole punching and cell reads, and holds the response item.
// ----------------------------------------------------------------------------
module dmg_ctrl
    import dmg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_req_type,
    output logic     o_in_ready,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    output logic     o_resp_kind,
    output logic     o_cell_is_wall,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_OPEN0, S_SHUF3, S_SHUF2, S_SHUF1, S_PROBE, S_CHK,
        S_MID, S_DST, S_POP, S_POPLD, S_HM1, S_HM2, S_DIVK, S_KLD,
        S_HCHK, S_HSEL, S_DIVX, S_WAITX, S_XLD, S_DIVY, S_WAITY, S_YWR,
        S_RDANS, S_GENANS
    } t_state;

    t_state     r_state;
    logic [1:0] r_dir;
    logic       r_out_valid, r_out_kind, r_out_wall;
    logic       accept;

    assign o_in_ready     = (r_state == S_IDLE) && !r_out_valid;
    assign accept         = o_in_ready && i_in_valid;
    assign o_out_valid    = r_out_valid;
    assign o_resp_kind    = r_out_kind;
    assign o_cell_is_wall = r_out_wall;

    // Command decode
    always_comb begin
        o_cmd.idx = r_dir;
        unique case (r_state)
            S_IDLE: begin
                if (!accept) begin
                    o_cmd.op = OP_NONE;
                end else if (i_req_type == REQ_GENERATE) begin
                    o_cmd.op = OP_GEN_START;
                end else begin
                    o_cmd.op = OP_READ;
                end
            end
            S_CLR:   o_cmd.op = OP_CLR;
            S_OPEN0: o_cmd.op = OP_OPEN_START;
            S_SHUF3: begin
                o_cmd.op  = OP_SHUF;
                o_cmd.idx = 2'd3;
            end
            S_SHUF2: begin
                o_cmd.op  = OP_SHUF;
                o_cmd.idx = 2'd2;
            end
            S_SHUF1: begin
                o_cmd.op  = OP_SHUF;
                o_cmd.idx = 2'd1;
            end
            S_PROBE: o_cmd.op = OP_PROBE;
            S_MID:   o_cmd.op = OP_OPEN_MID;
            S_DST:   o_cmd.op = OP_OPEN_DST;
            S_POP:   o_cmd.op = OP_POP_RD;
            S_POPLD: o_cmd.op = OP_POP_LOAD;
            S_HM1:   o_cmd.op = OP_HMUL1;
            S_HM2:   o_cmd.op = OP_HMUL2;
            S_DIVK:  o_cmd.op = OP_DIVK;
            S_KLD:   o_cmd.op = OP_KLOAD;
            S_HSEL:  o_cmd.op = OP_HSEL;
            S_DIVX:  o_cmd.op = OP_DIVX;
            S_XLD:   o_cmd.op = OP_XLOAD;
            S_DIVY:  o_cmd.op = OP_DIVY;
            S_YWR:   o_cmd.op = OP_YWRITE;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    // State and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dir       <= '0;
            r_out_valid <= 1'b0;
            r_out_kind  <= RESP_GEN;
            r_out_wall  <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= (i_req_type == REQ_GENERATE) ? S_CLR : S_RDANS;
                    end
                end
                S_CLR: begin
                    if (i_stat.clr_last) begin
                        r_state <= S_OPEN0;
                    end
                end
                S_OPEN0: r_state <= S_SHUF3;
                S_SHUF3: r_state <= S_SHUF2;
                S_SHUF2: r_state <= S_SHUF1;
                S_SHUF1: begin
                    r_dir   <= '0;
                    r_state <= S_PROBE;
                end
                S_PROBE: r_state <= S_CHK;
                // take the first in-bounds neighbor still walled, else backtrack or finish
                S_CHK: begin
                    if (i_stat.probe_hit) begin
                        r_state <= S_MID;
                    end else if (r_dir == 2'd3) begin
                        r_state <= i_stat.stack_empty ? S_HM1 : S_POP;
                    end else begin
                        r_dir   <= r_dir + 1'b1;
                        r_state <= S_PROBE;
                    end
                end
                S_MID:   r_state <= S_DST;
                S_DST:   r_state <= S_SHUF3;
                S_POP:   r_state <= S_POPLD;
                S_POPLD: r_state <= S_SHUF3;
                S_HM1:   r_state <= S_HM2;
                S_HM2:   r_state <= S_DIVK;
                S_DIVK:  r_state <= S_KLD;
                S_KLD:   r_state <= S_HCHK;
                S_HCHK:  r_state <= i_stat.k_zero ? S_GENANS : S_HSEL;
                S_HSEL:  r_state <= S_DIVX;
                S_DIVX:  r_state <= S_WAITX;
                S_WAITX: begin
                    if (!i_stat.div_busy) begin
                        r_state <= S_XLD;
                    end
                end
                S_XLD:   r_state <= S_DIVY;
                S_DIVY:  r_state <= S_WAITY;
                S_WAITY: begin
                    if (!i_stat.div_busy) begin
                        r_state <= S_YWR;
                    end
                end
                S_YWR:   r_state <= S_HCHK;
                S_RDANS: begin
                    r_out_valid <= 1'b1;
                    r_out_kind  <= RESP_READ;
                    r_out_wall  <= i_stat.rd_wall;
                    r_state     <= S_IDLE;
                end
                S_GENANS: begin
                    r_out_valid <= 1'b1;
                    r_out_kind  <= RESP_GEN;
                    r_out_wall  <= 1'b0;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Checks
    a_hit_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK && i_stat.probe_hit) |=> (r_state == S_MID))
        else $error("carve step lost after hit");
    a_resp_from_ans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_RDANS || $past(r_state) == S_GENANS))
        else $error("response raised outside answer state");
    a_gen_resp_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == RESP_GEN) |-> !r_out_wall)
        else $error("generate response carries wall bit");

endmodule

/* hw/rtl/dfs_maze_generator_unit.sv */
// ----------------------------------------------------------------------------
// dfs_maze_generator_unit: recursive backtracker maze generator
// Top level joining the request sequencer and the grid datapath.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one item per request: req_type 0 generates a new maze from
//   random_seed, req_type 1 reads the wall bit at (cell_x, cell_y). Every
//   request gives exactly one item on o_resp.
//   Sizes and hole rate are written through i_cfg_we/i_cfg_idx/i_cfg_data
//   while the unit is idle; they are sampled when a generate starts.
//   A read registers the wall bit from the grid, then the answer state loads
//   it into the response register. A generate first sweeps the whole grid
//   to walls, one cell per cycle, then carves: each step shuffles the four
//   directions and probes neighbors in turn, then opens the middle and new
//   cell, or pops the stack to backtrack. The hole count is then computed,
//   and each hole draws its column and row as modulo results of the divider.
//   One request is processed at a time; a new request is taken only once
//   the previous response has left the output register.
//   Reset sets the registers to 31 x 31 and rate 0; reads before the first
//   generate answer wall. A stalled receiver simply holds the response.
// ----------------------------------------------------------------------------
module dfs_maze_generator_unit
    import dmg_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    dmg_req_if.sink               i_req,
    dmg_resp_if.source            o_resp
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer
    dmg_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_req.valid),
        .i_req_type     (i_req.req_type),
        .o_in_ready     (i_req.ready),
        .i_out_ready    (o_resp.ready),
        .o_out_valid    (o_resp.valid),
        .o_resp_kind    (o_resp.resp_kind),
        .o_cell_is_wall (o_resp.cell_is_wall),
        .o_cmd          (cmd),
        .i_stat         (stat)
    );

    // Grid, stack and arithmetic
    dmg_datapath #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_seed     (i_req.random_seed),
        .i_cell_x   (i_req.cell_x),
        .i_cell_y   (i_req.cell_y),
        .i_cmd      (cmd),
        .o_stat     (stat)
    );

endmodule
